/* design/assert_macros.svh */
// Assertion macros used by the embedder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* design/lsbse_pkg.sv */
// Types, codes and helper functions of the LSB steganography embedder.
package lsbse_pkg;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_COVER   = 1'b1;

    localparam logic [2:0] ST_EMBEDDED = 3'd0;
    localparam logic [2:0] ST_PADDED   = 3'd1;
    localparam logic [2:0] ST_PASSED   = 3'd2;
    localparam logic [2:0] ST_STARVED  = 3'd3;
    localparam logic [2:0] ST_ACCEPTED = 3'd4;
    localparam logic [2:0] ST_REFUSED  = 3'd5;

    localparam logic [3:0] N_RESET = 4'd1;
    localparam logic [3:0] N_MAX   = 4'd8;
    localparam logic [4:0] BUF_FULL_LIMIT = 5'd8;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       message_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [15:0] bit_buffer;
        logic [4:0]  bit_count;
        logic        message_ended;
        logic        embedding_done;
    } embed_state_t;

    // Mask of the k low bits, k = 0..16 (all ones from 16 up).
    function automatic logic [15:0] low_mask(input logic [4:0] k);
        logic [16:0] m;
        m = (17'd1 << k) - 17'd1;
        return (k >= 5'd16) ? 16'hFFFF : m[15:0];
    endfunction

endpackage

/* design/lsb_stego_embedder.sv */
// Top level of the LSB steganography embedder: input stage, embed state and result stage.
// The block hides a message in the low n bits of cover bytes, oldest message bit first,
// n being the value written on the configuration channel (0 acts as 1, above 8 as 8).
// Items on the slave stream are message bytes (tuser = 0, tlast marks the final one) or
// cover bytes (tuser = 1); every item yields exactly one result item whose tuser carries a
// status code and whose tdata carries the cover byte (zero for message loads). Throughput
// is one item per clock unless the result stalls: the embed step updates the bit buffer
// combinationally between the input register and the result register, which each item
// passes in turn; a stalled result holds the input register and then s_tready.
// Write the configuration only while no item is in flight.
`include "assert_macros.svh"

module lsb_stego_embedder (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: bits_per_byte
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // message_last
    input  logic [0:0] s_tuser,   // [0] opcode
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser    // [2:0] status
);

    logic                    in_valid_reg;
    lsbse_pkg::item_t        in_item_reg;
    logic                    m_valid_reg;
    lsbse_pkg::result_t      m_result_reg;
    lsbse_pkg::embed_state_t state_reg;
    lsbse_pkg::embed_state_t state_next;
    lsbse_pkg::result_t      result_next;
    logic [3:0]              n_reg;
    logic                    out_free;
    logic                    advance;

    // Advance an item when the result register is empty or being drained.
    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lsbse_core u_core (
        .cfg_n      (n_reg),
        .item       (in_item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= lsbse_pkg::N_RESET;
        end else if (cfg_valid && cfg_ready) begin
            n_reg <= cfg_data;
        end
    end

    // Input stage: hold the item until the embed step takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode       <= s_tuser[0];
            in_item_reg.data_byte    <= s_tdata;
            in_item_reg.message_last <= s_tlast;
        end
    end

    // Embed state: update once per advanced item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_result_reg.out_byte;
    assign m_tuser  = m_result_reg.status;

    `ASSERT_ALWAYS(a_count_range, aclk, aresetn, state_reg.bit_count <= 5'd16)
    `ASSERT_IMPLIES(a_done_drained, aclk, aresetn, state_reg.embedding_done, state_reg.message_ended && state_reg.bit_count == 5'd0)
    `ASSERT_NEXT(a_load_count, aclk, aresetn, advance && result_next.status == lsbse_pkg::ST_ACCEPTED, state_reg.bit_count == $past(state_reg.bit_count) + 5'd8)
    `ASSERT_IMPLIES(a_load_zero_byte, aclk, aresetn, m_valid_reg && (m_result_reg.status == lsbse_pkg::ST_ACCEPTED || m_result_reg.status == lsbse_pkg::ST_REFUSED), m_result_reg.out_byte == 8'd0)

endmodule

/* design/lsbse_core.sv */
// Combinational embed step: one item and the current state give the result and next state.
module lsbse_core (
    input  logic [3:0]              cfg_n,
    input  lsbse_pkg::item_t        item,
    input  lsbse_pkg::embed_state_t state_cur,
    output lsbse_pkg::embed_state_t state_next,
    output lsbse_pkg::result_t      result
);

    logic [3:0]  n;
    logic [4:0]  n5;
    logic [15:0] slot_wide;
    logic [7:0]  slot;
    logic [4:0]  remain;
    logic [15:0] shifted;
    logic [15:0] kept;
    logic [3:0]  pad;
    logic [7:0]  chunk;
    logic [7:0]  padded;

    // Clamp the configured width to 1..8.
    always_comb begin
        if (cfg_n == 4'd0) begin
            n = lsbse_pkg::N_RESET;
        end else if (cfg_n > lsbse_pkg::N_MAX) begin
            n = lsbse_pkg::N_MAX;
        end else begin
            n = cfg_n;
        end
    end

    assign n5        = {1'b0, n};
    assign slot_wide = lsbse_pkg::low_mask(n5);
    assign slot      = slot_wide[7:0];
    assign remain    = state_cur.bit_count - n5;
    assign shifted   = state_cur.bit_buffer >> remain[3:0];
    assign chunk     = shifted[7:0] & slot;
    assign kept      = state_cur.bit_buffer & lsbse_pkg::low_mask(state_cur.bit_count);
    assign pad       = n - state_cur.bit_count[3:0];
    assign padded    = (kept[7:0] << pad) & slot;

    always_comb begin
        state_next      = state_cur;
        result.out_byte = 8'd0;
        result.status   = lsbse_pkg::ST_REFUSED;
        if (item.opcode == lsbse_pkg::OP_MESSAGE) begin
            if (!(state_cur.message_ended || state_cur.bit_count > lsbse_pkg::BUF_FULL_LIMIT))
            begin
                state_next.bit_buffer = {state_cur.bit_buffer[7:0], item.data_byte};
                state_next.bit_count  = state_cur.bit_count + 5'd8;
                if (item.message_last) begin
                    state_next.message_ended = 1'b1;
                end
                result.status = lsbse_pkg::ST_ACCEPTED;
            end
        end else if (state_cur.embedding_done) begin
            result.out_byte = item.data_byte;
            result.status   = lsbse_pkg::ST_PASSED;
        end else if (state_cur.bit_count >= n5) begin
            // Take the n oldest bits.
            result.out_byte       = (item.data_byte & ~slot) | chunk;
            result.status         = lsbse_pkg::ST_EMBEDDED;
            state_next.bit_count  = remain;
            state_next.bit_buffer = state_cur.bit_buffer & lsbse_pkg::low_mask(remain);
            if (state_cur.message_ended && remain == 5'd0) begin
                state_next.embedding_done = 1'b1;
            end
        end else if (state_cur.message_ended && state_cur.bit_count != 5'd0) begin
            // Left-align the short tail in the slot, zeros below.
            result.out_byte           = (item.data_byte & ~slot) | padded;
            result.status             = lsbse_pkg::ST_PADDED;
            state_next.bit_count      = 5'd0;
            state_next.bit_buffer     = 16'd0;
            state_next.embedding_done = 1'b1;
        end else if (state_cur.message_ended) begin
            result.out_byte           = item.data_byte;
            result.status             = lsbse_pkg::ST_PASSED;
            state_next.embedding_done = 1'b1;
        end else begin
            result.out_byte = item.data_byte;
            result.status   = lsbse_pkg::ST_STARVED;
        end
    end

endmodule
